@@ sv/lad_pkg.sv @@
package lad_pkg;

   // Queue geometry
   localparam int DEPTH  = 4;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Item field widths
   localparam int OP_W     = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int HELD_W   = 3;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INS_REAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_INS_FRONT = 2'd1;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 2'd2;
   localparam logic [OP_W-1:0] OP_DEL_REAR  = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_FRONT = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] removed_value;
      logic [HELD_W-1:0]         held_count;
   } result_type;

endpackage

@@ sv/lad_core.sv @@
module lad_core
   import lad_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  logic [OP_W-1:0]           operation,
   input  logic signed [VALUE_W-1:0] value,
   output result_type                result
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [IDX_W-1:0] ZERO_IDX = '0;

   logic signed [VALUE_W-1:0] slots_ff [DEPTH];
   logic [IDX_W-1:0]          front_ff, front_in;
   logic [IDX_W-1:0]          rear_ff, rear_in;
   logic                      empty_ff, empty_in;

   logic                      wr_en;
   logic [IDX_W-1:0]          wr_idx;
   logic [IDX_W-1:0]          rd_idx;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] removed;
   logic [CNT_W-1:0]          count;

   always_comb begin
      front_in = front_ff;
      rear_in  = rear_ff;
      empty_in = empty_ff;
      wr_en    = 1'b0;
      wr_idx   = ZERO_IDX;
      rd_idx   = (operation == OP_DEL_FRONT) ? front_ff : rear_ff;
      status   = ST_OK;
      removed  = '0;
      case (operation)
         OP_INS_REAR, OP_INS_FRONT: begin
            if (empty_ff) begin
               front_in = ZERO_IDX;
               rear_in  = ZERO_IDX;
               empty_in = 1'b0;
               wr_en    = 1'b1;
            end else if (operation == OP_INS_REAR) begin
               if (rear_ff == LAST_IDX) begin
                  status = ST_OVERFLOW;
               end else begin
                  rear_in = rear_ff + 1'b1;
                  wr_en   = 1'b1;
                  wr_idx  = rear_ff + 1'b1;
               end
            end else begin
               if (front_ff == ZERO_IDX) begin
                  status = ST_NO_FRONT;
               end else begin
                  front_in = front_ff - 1'b1;
                  wr_en    = 1'b1;
                  wr_idx   = front_ff - 1'b1;
               end
            end
         end
         OP_DEL_FRONT, OP_DEL_REAR: begin
            if (empty_ff) begin
               status = ST_UNDERFLOW;
            end else begin
               removed = slots_ff[rd_idx];
               if (front_ff == rear_ff) begin
                  // last element out: back to the reset shape
                  front_in = ZERO_IDX;
                  rear_in  = ZERO_IDX;
                  empty_in = 1'b1;
               end else if (operation == OP_DEL_FRONT) begin
                  front_in = front_ff + 1'b1;
               end else begin
                  rear_in = rear_ff - 1'b1;
               end
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
      // rear never sits below front while non-empty
      count = empty_in ? '0
                       : CNT_W'({1'b0, rear_in - front_in}) + CNT_W'(1);
   end

   assign result.status        = status;
   assign result.removed_value = removed;
   assign result.held_count    = HELD_W'(count);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= ZERO_IDX;
         rear_ff  <= ZERO_IDX;
         empty_ff <= 1'b1;
      end else if (fire) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && wr_en) begin
         slots_ff[wr_idx] <= value;
      end
   end

endmodule

@@ sv/linear_array_deque_top.sv @@
// Linear-array deque, one request item in, one response item out.
// Path: an accepted request is held in the input register, then the queue update
// computed from it is registered into the response register.
// Throughput: 1 item per cycle; the response register stalls the pipe only
// while rsp_tready is low.
// Reset: synchronous; queue empty, both pipeline registers empty.
module linear_array_deque_top
   import lad_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [31:0] value
   input  logic [OP_W-1:0]       req_tuser,  // [1:0] operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [31:0] removed_value, [34:32] held_count
   output logic [STATUS_W-1:0]   rsp_tuser   // [1:0] status
);

   logic                      in_valid_ff;
   logic [OP_W-1:0]           op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic                      out_valid_ff;
   result_type                result_ff;
   result_type                result_in;
   logic                      advance;
   logic                      fire;

   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         op_ff    <= req_tuser;
         value_ff <= req_tdata[VALUE_W-1:0];
      end
   end

   lad_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .operation (op_ff),
      .value     (value_ff),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = result_ff.status;
   assign rsp_tdata  = {{(RSP_DATA_W - VALUE_W - HELD_W){1'b0}},
                        result_ff.held_count, result_ff.removed_value};

endmodule

@@ sv/lad_checker.sv @@
module lad_checker
   import lad_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser
);

   logic [HELD_W-1:0]         held;
   logic signed [VALUE_W-1:0] removed;

   assign held    = rsp_tdata[VALUE_W +: HELD_W];
   assign removed = rsp_tdata[VALUE_W-1:0];

   // nothing comes out the cycle after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> held <= HELD_W'(DEPTH))
      else $error("held count above depth");

   a_fail_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> removed == '0)
      else $error("failed operation returned a value");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_UNDERFLOW |-> held == '0)
      else $error("underflow with elements held");

endmodule

bind linear_array_deque_top lad_checker u_lad_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ dv/linear_array_deque_top_test.sv @@
module linear_array_deque_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lad_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int MAX_REPORTS  = 10;
   localparam int RANDOM_ITEMS = 2000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // [31:0] value
   logic [OP_W-1:0]       req_tuser = '0;  // [1:0] operation
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // [31:0] removed_value, [34:32] held_count
   logic [STATUS_W-1:0]   rsp_tuser;       // [1:0] status

   // Predicted deque contents
   logic [VALUE_W-1:0] dq_slots [DEPTH];
   int                 dq_head = 0;
   int                 dq_tail = 0;
   bit                 dq_empty = 1'b1;

   result_type pending_results [$];
   result_type want_rsp;
   int         mismatch_count = 0;
   int         idle_cycles = 0;
   int         ready_hold = 0;
   int         stall_len;
   bit         calm = 1'b0;

   linear_array_deque_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // mostly short gaps, a few long ones; none while calm
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (calm || r < 50) return 0;
      if (r < 93) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic result_type apply_deque_op(input logic [OP_W-1:0] op,
                                                 input logic [VALUE_W-1:0] value);
      result_type res;
      res.status        = ST_OK;
      res.removed_value = '0;
      case (op)
         OP_INS_REAR: begin
            if (dq_empty) begin
               dq_head     = 0;
               dq_tail     = 0;
               dq_empty    = 1'b0;
               dq_slots[0] = value;
            end else if (dq_tail >= DEPTH - 1) begin
               res.status = ST_OVERFLOW;
            end else begin
               dq_tail++;
               dq_slots[dq_tail] = value;
            end
         end
         OP_INS_FRONT: begin
            if (dq_empty) begin
               dq_head     = 0;
               dq_tail     = 0;
               dq_empty    = 1'b0;
               dq_slots[0] = value;
            end else if (dq_head != 0) begin
               dq_head--;
               dq_slots[dq_head] = value;
            end else begin
               // no room before slot 0, even with free slots at the rear
               res.status = ST_NO_FRONT;
            end
         end
         OP_DEL_FRONT: begin
            if (dq_empty) begin
               res.status = ST_UNDERFLOW;
            end else begin
               res.removed_value = dq_slots[dq_head];
               if (dq_head == dq_tail) begin
                  dq_empty = 1'b1;
                  dq_head  = 0;
                  dq_tail  = 0;
               end else begin
                  dq_head++;
               end
            end
         end
         default: begin
            if (dq_empty) begin
               res.status = ST_UNDERFLOW;
            end else begin
               res.removed_value = dq_slots[dq_tail];
               if (dq_head == dq_tail) begin
                  dq_empty = 1'b1;
                  dq_head  = 0;
                  dq_tail  = 0;
               end else begin
                  dq_tail--;
               end
            end
         end
      endcase
      res.held_count = dq_empty ? '0 : HELD_W'(dq_tail - dq_head + 1);
      return res;
   endfunction

   // valid stays high across back-to-back items; lowered only for a gap
   task automatic issue_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(apply_deque_op(op, value));
   endtask

   task automatic test_empty_deletes();
      issue_op(OP_DEL_FRONT, 32'h1234_5678);
      issue_op(OP_DEL_REAR, 32'hFFFF_FFFF);
   endtask

   task automatic test_single_element();
      issue_op(OP_INS_FRONT, 32'h7FFF_FFFF);
      issue_op(OP_DEL_REAR, 32'h0);
      issue_op(OP_INS_REAR, 32'h8000_0000);
      issue_op(OP_DEL_FRONT, 32'h0);
   endtask

   task automatic test_front_blocked();
      issue_op(OP_INS_REAR, 32'h0);
      issue_op(OP_INS_FRONT, 32'hAAAA_AAAA);
   endtask

   task automatic test_fill_and_drain();
      issue_op(OP_INS_REAR, 32'hFFFF_FFFF);
      issue_op(OP_INS_REAR, 32'h0000_0001);
      issue_op(OP_INS_REAR, 32'h5555_5555);
      issue_op(OP_INS_REAR, 32'hDEAD_BEEF);
      issue_op(OP_DEL_FRONT, 32'h0);
      issue_op(OP_DEL_FRONT, 32'h0);
      // rear at the last slot overflows although the front has room
      issue_op(OP_INS_REAR, 32'h0BAD_F00D);
      issue_op(OP_INS_FRONT, 32'h8000_0000);
      issue_op(OP_INS_FRONT, 32'h7FFF_FFFF);
      issue_op(OP_INS_FRONT, 32'hAAAA_AAAA);
      issue_op(OP_DEL_REAR, 32'h0);
      issue_op(OP_DEL_REAR, 32'h0);
      issue_op(OP_DEL_REAR, 32'h0);
      issue_op(OP_DEL_REAR, 32'h0);
      issue_op(OP_DEL_REAR, 32'h0);
   endtask

   task automatic test_random_traffic();
      int               fill_bias;
      int               r;
      logic [OP_W-1:0]  op;
      logic [VALUE_W-1:0] value;
      fill_bias = 50;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 150 == 0) begin
            calm      = ($urandom_range(3) == 0);
            fill_bias = $urandom_range(80, 20);
         end
         r = $urandom_range(99);
         if (r < fill_bias) begin
            op = $urandom_range(1) ? OP_INS_REAR : OP_INS_FRONT;
         end else begin
            op = $urandom_range(1) ? OP_DEL_FRONT : OP_DEL_REAR;
         end
         case ($urandom_range(9))
            0: value = 32'h8000_0000;
            1: value = 32'h7FFF_FFFF;
            2: value = 32'h0;
            3: value = 32'hFFFF_FFFF;
            default: value = $urandom();
         endcase
         issue_op(op, value);
      end
      calm = 1'b0;
   endtask

   // response backpressure
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else if (rsp_tready) begin
         stall_len = pick_gap();
         if (stall_len > 0) begin
            rsp_tready <= 1'b0;
            ready_hold <= stall_len - 1;
         end
      end else begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(6, 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("unexpected response item: status=%0d tdata=%h", rsp_tuser, rsp_tdata);
            end
         end else begin
            want_rsp = pending_results.pop_front();
            if (rsp_tuser !== want_rsp.status ||
                rsp_tdata[31:0] !== want_rsp.removed_value ||
                rsp_tdata[34:32] !== want_rsp.held_count ||
                rsp_tdata[RSP_DATA_W-1:35] !== '0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("mismatch: expected status=%0d removed=%0d held=%0d pad=0",
                           want_rsp.status, want_rsp.removed_value, want_rsp.held_count);
                  $display("          actual   status=%0d removed=%0d held=%0d pad=%h",
                           rsp_tuser, $signed(rsp_tdata[31:0]), rsp_tdata[34:32],
                           rsp_tdata[RSP_DATA_W-1:35]);
               end
            end
         end
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_deletes();
      test_single_element();
      test_front_blocked();
      test_fill_and_drain();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
